FILE: rtl/swmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window statistics package
// Shared widths and the queue entry type for the mean and deviation block.
// ----------------------------------------------------------------------------
package swmd_pkg;

  localparam int unsigned MaxWindow = 256;
  localparam int unsigned SampleW   = 24;
  localparam int unsigned CountW    = 9;
  localparam int unsigned SumW      = 32;
  localparam int unsigned SqSumW    = 64;

  // One queue entry: window sums and count after the new sample.
  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic [SqSumW-1:0]      sq_sum;
    logic [CountW-1:0]      count;
  } swmd_job_t;

endpackage

FILE: rtl/swmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window front end
// Stores samples in a ring memory and keeps the exact window sums.
// ----------------------------------------------------------------------------
module swmd_front import swmd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CountW-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] in_sample_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output swmd_job_t                 job_o
);

  localparam int unsigned AddrW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned HeldW = $clog2(MaxWindow + 1);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StUpdate,
    StPush
  } state_e;

  state_e state_q;
  logic signed [SampleW-1:0] ring_mem [MaxWindow];
  logic signed [SampleW-1:0] old_q, new_q;
  logic [AddrW-1:0] head_q;
  logic [HeldW-1:0] held_q;
  logic [CountW-1:0] len_q;
  logic signed [SumW-1:0] sum_q;
  logic [SqSumW-1:0] sq_q;
  logic evict_q;
  logic [HeldW-1:0] eff_len;
  logic [AddrW-1:0] old_addr;
  logic signed [2*SampleW-1:0] old_sq, new_sq;

  always_comb begin
    if (len_q < CountW'(2)) begin
      eff_len = HeldW'(2);
    end else if (32'(len_q) > MaxWindow) begin
      eff_len = HeldW'(MaxWindow);
    end else begin
      eff_len = HeldW'(len_q);
    end
  end

  assign old_addr = head_q - AddrW'(held_q);
  assign old_sq   = old_q * old_q;
  assign new_sq   = new_q * new_q;
  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i) begin
    if (state_q == StUpdate) begin
      ring_mem[head_q] <= new_q;
    end
    old_q <= ring_mem[old_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      held_q  <= '0;
      len_q   <= CountW'(128);
      sum_q   <= '0;
      sq_q    <= '0;
      evict_q <= 1'b0;
      new_q   <= '0;
      job_valid_o <= 1'b0;
      job_o   <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q  <= cfg_wdata_i;
        head_q <= '0;
        held_q <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            new_q   <= in_sample_i;
            evict_q <= (held_q >= eff_len);
            state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= StUpdate;
        end
        StUpdate: begin
          if (evict_q) begin
            sum_q  <= sum_q - SumW'(old_q) + SumW'(new_q);
            sq_q   <= sq_q - SqSumW'(old_sq) + SqSumW'(new_sq);
            held_q <= eff_len;
          end else begin
            sum_q  <= sum_q + SumW'(new_q);
            sq_q   <= sq_q + SqSumW'(new_sq);
            held_q <= held_q + HeldW'(1);
          end
          head_q  <= head_q + AddrW'(1);
          state_q <= StPush;
        end
        StPush: begin
          if (!job_valid_o || job_ready_i) begin
            job_o.sum    <= sum_q;
            job_o.sq_sum <= sq_q;
            job_o.count  <= CountW'(held_q);
            job_valid_o  <= 1'b1;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (job_valid_o && job_ready_i && state_q != StPush) begin
        job_valid_o <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(MaxWindow))
    else $error("held count exceeds window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == StRead)
    else $error("accepted sample not processed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> job_o.count != '0)
    else $error("job with empty window");

endmodule

FILE: rtl/swmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window back end
// Divides the sums and takes the square root, one bit per cycle.
// ----------------------------------------------------------------------------
module swmd_back import swmd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  swmd_job_t                 job_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] out_mean_o,
  output logic [SampleW-1:0]        out_dev_o,
  output logic [CountW-1:0]         out_held_o
);

  localparam int unsigned NumW = 128;
  localparam int unsigned DenW = 17;

  typedef enum logic [2:0] {
    StIdle,
    StMulA,
    StMulB,
    StDivMean,
    StDivVar,
    StSqrt,
    StDone
  } state_e;

  state_e state_q;
  logic [7:0] step_q;
  logic [CountW-1:0] n_q;
  logic sum_neg_q;
  logic [SumW-1:0] mag_q;
  logic [SqSumW-1:0] sq_q;
  logic [NumW-1:0] prod_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [63:0] x_q, res_q, bit_q;
  logic [SumW-1:0] mean_mag_q;
  logic [DenW:0] rem_sh;
  logic [63:0] trial;

  assign job_ready_o = (state_q == StIdle) && !out_valid_o;
  assign rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign trial  = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_o <= 1'b0;
      step_q <= '0;
      n_q <= '0;
      sum_neg_q <= 1'b0;
      mag_q <= '0;
      sq_q <= '0;
      prod_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      den_q <= '0;
      x_q <= '0;
      res_q <= '0;
      bit_q <= '0;
      mean_mag_q <= '0;
      out_mean_o <= '0;
      out_dev_o <= '0;
      out_held_o <= '0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (job_valid_i && !out_valid_o) begin
            n_q       <= job_i.count;
            sum_neg_q <= job_i.sum[SumW-1];
            mag_q     <= job_i.sum[SumW-1] ? -job_i.sum : job_i.sum;
            sq_q      <= job_i.sq_sum;
            den_q     <= DenW'(job_i.count);
            quo_q     <= {(NumW-SumW)'(0),
                          job_i.sum[SumW-1] ? -job_i.sum : job_i.sum};
            rem_q     <= '0;
            step_q    <= '0;
            state_q   <= StDivMean;
          end
        end
        StDivMean: begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          step_q <= step_q + 8'd1;
          if (step_q == 8'(NumW-1)) begin
            state_q <= StMulA;
          end
        end
        StMulA: begin
          mean_mag_q <= quo_q[SumW-1:0];
          prod_q <= NumW'(sq_q) * NumW'(n_q);
          state_q <= StMulB;
        end
        StMulB: begin
          quo_q <= prod_q - NumW'(64'(mag_q) * 64'(mag_q));
          den_q <= DenW'(n_q) * DenW'(n_q - CountW'(1));
          rem_q <= '0;
          step_q <= '0;
          state_q <= (n_q < CountW'(2)) ? StDone : StDivVar;
          res_q <= 64'd16;
        end
        StDivVar: begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          step_q <= step_q + 8'd1;
          if (step_q == 8'(NumW-1)) begin
            state_q <= StSqrt;
            step_q <= '0;
            res_q <= '0;
            bit_q <= 64'd1 << 62;
          end
        end
        StSqrt: begin
          if (step_q == 8'd0) begin
            if (|quo_q[NumW-1:64]) begin
              res_q <= 64'hFFFFFF;
              state_q <= StDone;
            end else begin
              x_q <= quo_q[63:0];
              step_q <= 8'd1;
            end
          end else begin
            if (x_q >= trial) begin
              x_q <= x_q - trial;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
            step_q <= step_q + 8'd1;
            if (step_q == 8'd32) begin
              state_q <= StDone;
            end
          end
        end
        StDone: begin
          out_mean_o <= sum_neg_q ? -SampleW'(mean_mag_q) : SampleW'(mean_mag_q);
          if (n_q < CountW'(2)) begin
            out_dev_o <= SampleW'(256);
          end else if (|res_q[63:24]) begin
            out_dev_o <= '1;
          end else begin
            out_dev_o <= res_q[23:0];
          end
          out_held_o <= n_q;
          out_valid_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_held_o != '0)
    else $error("result with empty window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && job_ready_o) |=> state_q == StDivMean)
    else $error("job not started");

endmodule

FILE: rtl/sliding_window_mean_deviation.sv
`timescale 1ns / 1ps
// The back end runs a 128-step bit-serial division for the mean and, when
// two or more samples are held, a second one and a 32-step square root.
// The front end takes the next sample while the back end works.
// Reset empties the window and sets the window length to 128.
// ----------------------------------------------------------------------------
// Sliding window mean and deviation
// Front end keeps window sums, back end computes mean and deviation.
// ----------------------------------------------------------------------------
module sliding_window_mean_deviation import swmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // sample[23:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata   // mean, deviation, samples_held, pad
);

  logic      job_valid, job_ready;
  swmd_job_t job;
  logic signed [SampleW-1:0] mean;
  logic [SampleW-1:0] dev;
  logic [CountW-1:0] held;

  swmd_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_sample_i(s_axis_tdata),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  swmd_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_mean_o(mean), .out_dev_o(dev), .out_held_o(held)
  );

  assign m_axis_tdata = {7'd0, held, dev, mean};

endmodule
